/* rtl/fmn_pkg.sv */
// ----------------------------------------------------------------------------
// fmn_pkg
// Shared constants and types for the frame buffer with peak normalization.
// ----------------------------------------------------------------------------
package fmn_pkg;

  // defaults for top-level parameters
  localparam int DEF_MAX_WIDTH    = 128;
  localparam int DEF_MAX_HEIGHT   = 128;
  localparam int DEF_CHANNEL_BITS = 16;

  // fixed field widths
  localparam int COORD_BITS     = 7;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 8;
  localparam int OUT_BITS       = 8;
  localparam int NUM_CHANNELS   = 3;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd1;

  localparam logic [CFG_DATA_BITS-1:0] IMAGE_WIDTH_RESET = 8'd128;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // scaling: q = (c*2*255 + peak) / (2*peak), saturated at 255
  localparam logic [OUT_BITS-1:0] OUT_FULL = 8'd255;
  localparam int NUM_SCALE      = 510;
  localparam int NUM_EXTRA_BITS = 10;   // c*510 + peak fits in CHANNEL_BITS+10 bits

  // one saturation check plus one step per quotient bit
  localparam int DIV_STEPS = OUT_BITS + 1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* rtl/fmn_store.sv */
// ----------------------------------------------------------------------------
// fmn_store
// Single-port pixel memory, registered read.
// ----------------------------------------------------------------------------
module fmn_store #(
  parameter int DEPTH = fmn_pkg::DEF_MAX_WIDTH * fmn_pkg::DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(fmn_pkg::DEF_MAX_WIDTH * fmn_pkg::DEF_MAX_HEIGHT),
  parameter int DW    = 3 * fmn_pkg::DEF_CHANNEL_BITS
) (
  input  logic             clk,
  input  fmn_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]    addr,
  input  logic [DW-1:0]    wdata,
  output logic [DW-1:0]    rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/fmn_divider.sv */
// ----------------------------------------------------------------------------
// fmn_divider
// Restoring divider for one channel: 8-bit quotient, saturates at full scale.
// ----------------------------------------------------------------------------
module fmn_divider #(
  parameter int CHANNEL_BITS = fmn_pkg::DEF_CHANNEL_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [CHANNEL_BITS+fmn_pkg::NUM_EXTRA_BITS-1:0] num,
  input  logic [CHANNEL_BITS:0]                           den,
  output logic                                            busy,
  output logic                                            done,
  output logic [fmn_pkg::OUT_BITS-1:0]                    quot
);

  localparam int NW = CHANNEL_BITS + fmn_pkg::NUM_EXTRA_BITS;
  localparam int CW = $clog2(fmn_pkg::DIV_STEPS + 1);
  localparam int QB = fmn_pkg::OUT_BITS;

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;     // divisor aligned to the current quotient bit
  logic [QB-1:0] q;
  logic          sat;
  logic [CW-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(fmn_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NW'(den) << (QB - 1);
      q   <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      if (cnt == CW'(fmn_pkg::DIV_STEPS)) begin
        // quotient would not fit in eight bits
        sat <= {1'b0, rem} >= {dsh, 1'b0};
      end else begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          q   <= {q[QB-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
    end
  end

  assign quot = sat ? fmn_pkg::OUT_FULL : q;

endmodule

/* rtl/framebuffer_max_normalize.sv */
// ----------------------------------------------------------------------------
// framebuffer_max_normalize
// Write item: stores the pixel and raises the running peak if in the store.
// Read item: RAM read, nine divider steps (none on zero peak or out of the
// store), output load when the output register is free, then back to idle.
// Synchronous reset: peak zero, image_width 128, no result. Pixel memory is
// not cleared; the user must read entries only once written (not enforced).
// ----------------------------------------------------------------------------
module framebuffer_max_normalize #(
  parameter int MAX_WIDTH    = fmn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = fmn_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = fmn_pkg::DEF_CHANNEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,

  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fmn_pkg::CFG_DATA_BITS-1:0]   cfg_data,

  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [fmn_pkg::COORD_BITS-1:0]      col,
  input  logic [fmn_pkg::COORD_BITS-1:0]      row,
  input  logic [CHANNEL_BITS-1:0]             red_in,
  input  logic [CHANNEL_BITS-1:0]             green_in,
  input  logic [CHANNEL_BITS-1:0]             blue_in,

  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fmn_pkg::OUT_BITS-1:0]        red_out,
  output logic [fmn_pkg::OUT_BITS-1:0]        green_out,
  output logic [fmn_pkg::OUT_BITS-1:0]        blue_out
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DEPTH_BITS  = $clog2(STORE_DEPTH + 1);
  // row*width+col spans coord + register bits, plus one for the carry
  localparam int CALC_MIN    = fmn_pkg::COORD_BITS + fmn_pkg::CFG_DATA_BITS + 1;
  localparam int CMP_BITS    = (DEPTH_BITS > CALC_MIN) ? DEPTH_BITS : CALC_MIN;
  localparam int NW          = CHANNEL_BITS + fmn_pkg::NUM_EXTRA_BITS;
  localparam int NCH         = fmn_pkg::NUM_CHANNELS;
  localparam int DW          = NCH * CHANNEL_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,   // accepts items
    ST_FETCH  = 4'b0010,   // RAM read data arrives
    ST_DIVIDE = 4'b0100,   // three divider lanes run
    ST_EMIT   = 4'b1000    // load output register when free
  } state_t;

  state_t                        state, state_next;
  logic [fmn_pkg::CFG_DATA_BITS-1:0] image_width;
  logic [CHANNEL_BITS-1:0]       peak_level;
  logic                          in_store_q;
  logic                          zero_q;

  // --------------------------------------------------------------------------
  // Configuration: always ready. Row count is accepted but does not enter
  // addressing, so it needs no storage.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= fmn_pkg::IMAGE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmn_pkg::REG_IMAGE_WIDTH:  image_width <= cfg_data;
        fmn_pkg::REG_IMAGE_HEIGHT: ;
        default:                   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Address and bound check (only the store bound applies, not the image size)
  // --------------------------------------------------------------------------
  logic [CMP_BITS-1:0] addr_calc;
  logic                in_store;

  assign addr_calc = CMP_BITS'(row) * CMP_BITS'(image_width) + CMP_BITS'(col);
  assign in_store  = addr_calc < CMP_BITS'(STORE_DEPTH);

  logic in_fire, wr_fire, rd_fire;
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_fire  = in_fire && (mode == fmn_pkg::MODE_WRITE) && in_store;
  assign rd_fire  = in_fire && (mode == fmn_pkg::MODE_READ);

  // --------------------------------------------------------------------------
  // Running peak: largest channel of every write that lands in the store
  // --------------------------------------------------------------------------
  logic [CHANNEL_BITS-1:0] max_rg, max_rgb, peak_next;

  always_comb begin
    max_rg    = (red_in > green_in) ? red_in : green_in;
    max_rgb   = (max_rg > blue_in) ? max_rg : blue_in;
    peak_next = (max_rgb > peak_level) ? max_rgb : peak_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= '0;
    end else if (wr_fire) begin
      peak_level <= peak_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel memory; red in the low slice. A read issued at accept has its data
  // in ST_FETCH. Only one item is in flight, so no write can overlap a read.
  // --------------------------------------------------------------------------
  fmn_pkg::mem_ctl_t mem_ctl;
  logic [DW-1:0]     rdata;

  assign mem_ctl.wr_en = wr_fire;
  assign mem_ctl.rd_en = rd_fire && in_store;

  fmn_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (addr_calc[AW-1:0]),
    .wdata ({blue_in, green_in, red_in}),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // Divider lanes, one per channel, started together from ST_FETCH.
  // Numerator c*510 + peak, divisor 2*peak: round half up of c*255/peak.
  // --------------------------------------------------------------------------
  logic                         div_start;
  logic [NCH-1:0]               div_busy;
  logic [NCH-1:0]               div_done;
  logic [fmn_pkg::OUT_BITS-1:0] quot [NCH];
  logic [CHANNEL_BITS:0]        den;

  assign den = {peak_level, 1'b0};

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    logic [NW-1:0] num;

    assign num = NW'(rdata[k*CHANNEL_BITS +: CHANNEL_BITS]) * NW'(fmn_pkg::NUM_SCALE)
               + NW'(peak_level);

    fmn_divider #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (num),
      .den   (den),
      .busy  (div_busy[k]),
      .done  (div_done[k]),
      .quot  (quot[k])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;

  assign out_load  = (state == ST_EMIT) && (!out_valid || out_ready);
  // zero peak or address beyond the store: black, no division
  assign div_start = (state == ST_FETCH) && in_store_q && (peak_level != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (rd_fire) state_next = ST_FETCH;
      ST_FETCH:  state_next = div_start ? ST_DIVIDE : ST_EMIT;
      ST_DIVIDE: if (&div_done) state_next = ST_EMIT;
      ST_EMIT:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      in_store_q <= in_store;
    end
    if (state == ST_FETCH) begin
      zero_q <= !div_start;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: holds a finished result while the block takes new items
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out   <= zero_q ? '0 : quot[0];
      green_out <= zero_q ? '0 : quot[1];
      blue_out  <= zero_q ? '0 : quot[2];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> peak_level >= $past(peak_level))
    else $error("peak level decreased");

  a_outside_write_no_peak: assert property (@(posedge clk) disable iff (rst)
    in_fire && (mode == fmn_pkg::MODE_WRITE) && !in_store
      |=> peak_level == $past(peak_level))
    else $error("write beyond store changed peak");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (div_busy == '0))
    else $error("divider busy while idle");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared outside emit");

endmodule

/* tb/sv/framebuffer_max_normalize_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_max_normalize_tb
// Self-checking bench for the peak-normalizing frame buffer. A queue-fed
// driver offers write and read items, a clocked monitor keeps its own copy of
// the pixel store, the running peak and the width register, and checks every
// normalized pixel against the predicted value. Both sides idle at random;
// the result side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module framebuffer_max_normalize_tb;
  import fmn_pkg::*;

  localparam int CH_BITS     = DEF_CHANNEL_BITS;
  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SCALE_NUM   = 2 * 255;   // round(c*255/peak) as (c*510+peak)/(2*peak)
  localparam int SETTLE      = 24;        // quiet cycles before a register write / the end

  // register index that the block does not decode
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 4'd15;

  typedef struct {
    logic                  mode;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [CH_BITS-1:0]    red;
    logic [CH_BITS-1:0]    green;
    logic [CH_BITS-1:0]    blue;
  } pixel_item_t;

  typedef struct {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } rgb8_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode     = MODE_WRITE;
  logic [COORD_BITS-1:0] col      = '0;
  logic [COORD_BITS-1:0] row      = '0;
  logic [CH_BITS-1:0]    red_in   = '0;
  logic [CH_BITS-1:0]    green_in = '0;
  logic [CH_BITS-1:0]    blue_in  = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_BITS-1:0] red_out;
  logic [OUT_BITS-1:0] green_out;
  logic [OUT_BITS-1:0] blue_out;

  framebuffer_max_normalize u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .col       (col),
    .row       (row),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  pixel_item_t item_q[$];         // items waiting to be offered
  rgb8_t       normalized_q[$];   // predicted read results, oldest first

  // handshake counters: issued is bumped by the driver, taken by the monitor
  int unsigned n_in_issued = 0;
  int unsigned n_in_taken  = 0;
  int unsigned n_out_taken = 0;
  int unsigned n_errors    = 0;

  // predictor state, updated on accepted items and register writes
  logic [3*CH_BITS-1:0] model_pixels [STORE_DEPTH];
  logic [CH_BITS-1:0]   model_peak   = '0;
  int unsigned          model_width  = 128;
  int unsigned          model_height = 128;

  // generator view: width in force when queued items will be taken, and
  // every in-store address that a queued write covers
  int unsigned plan_width = 128;
  int unsigned written_addrs[$];

  // long receiver hold-off
  int unsigned hold_cnt  = 0;
  bit          hold_done = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [OUT_BITS-1:0] scale_to_byte(input logic [CH_BITS-1:0] c,
                                                        input logic [CH_BITS-1:0] peak);
    longint unsigned q;
    if (peak == '0) return '0;
    q = (64'(c) * 64'(SCALE_NUM) + 64'(peak)) / (64'(peak) * 64'd2);
    if (q > 64'd255) q = 64'd255;   // only if a channel exceeded the peak
    return q[OUT_BITS-1:0];
  endfunction

  task automatic apply_item(input logic m, input logic [COORD_BITS-1:0] c,
                            input logic [COORD_BITS-1:0] r, input logic [CH_BITS-1:0] rd,
                            input logic [CH_BITS-1:0] gr, input logic [CH_BITS-1:0] bl);
    int unsigned          a;
    logic [3*CH_BITS-1:0] px;
    rgb8_t                res;
    // height is stored but plays no part in addressing
    a = r * model_width + c;
    if (m == MODE_WRITE) begin
      // out-of-store writes are dropped and leave the peak alone
      if (a < STORE_DEPTH) begin
        model_pixels[a] = {rd, gr, bl};
        if (rd > model_peak) model_peak = rd;
        if (gr > model_peak) model_peak = gr;
        if (bl > model_peak) model_peak = bl;
      end
    end else begin
      // out-of-store read still returns one result, all black
      px = (a < STORE_DEPTH) ? model_pixels[a] : '0;
      res.red   = scale_to_byte(px[3*CH_BITS-1:2*CH_BITS], model_peak);
      res.green = scale_to_byte(px[2*CH_BITS-1:CH_BITS], model_peak);
      res.blue  = scale_to_byte(px[CH_BITS-1:0], model_peak);
      normalized_q.push_back(res);
    end
  endtask

  function automatic void check_field(input string name, input logic [OUT_BITS-1:0] want,
                                      input logic [OUT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    rgb8_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  model_width  = cfg_data;
          REG_IMAGE_HEIGHT: model_height = cfg_data;
          default: ;   // undecoded index, ignored
        endcase
      end
      if (in_valid && in_ready) begin
        apply_item(mode, col, row, red_in, green_in, blue_in);
        n_in_taken++;
      end
      if (out_valid && out_ready) begin
        n_out_taken++;
        if (normalized_q.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 red_out, green_out, blue_out);
          n_errors++;
        end else begin
          want = normalized_q.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item driver: offers the next queued item after a random gap; payload
  // changes only at the falling edge and holds until taken
  // --------------------------------------------------------------------------
  int unsigned in_wait  = 0;
  bit          in_burst = 1'b0;

  always @(negedge clk) begin : item_driver
    pixel_item_t nxt;
    if (!rst && n_in_issued == n_in_taken) begin
      if (in_wait != 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        nxt = item_q.pop_front();
        mode     <= nxt.mode;
        col      <= nxt.col;
        row      <= nxt.row;
        red_in   <= nxt.red;
        green_in <= nxt.green;
        blue_in  <= nxt.blue;
        in_valid <= 1'b1;
        n_in_issued++;
        // occasional switch between idling and back-to-back stretches
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_wait = in_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: stalls each result for a random number of valid cycles
  // --------------------------------------------------------------------------
  int unsigned out_wait   = 0;
  int unsigned n_out_seen = 0;
  bit          out_burst  = 1'b0;

  always @(negedge clk) begin : result_sink
    if (!rst) begin
      if (n_out_taken != n_out_seen) begin
        n_out_seen = n_out_taken;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 6);
      end
      out_ready <= (hold_cnt == 0) && (out_wait == 0);
      if (out_valid && out_wait != 0) out_wait--;
    end
  end

  // one long hold-off early in the random part; the sender keeps offering,
  // so the block has to back up and drop in_ready
  always @(posedge clk) begin : hold_off_timer
    if (!rst) begin
      if (!hold_done && n_out_taken >= 60) begin
        hold_cnt  = 300;
        hold_done = 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic m, input logic [COORD_BITS-1:0] c,
                          input logic [COORD_BITS-1:0] r, input logic [CH_BITS-1:0] rd,
                          input logic [CH_BITS-1:0] gr, input logic [CH_BITS-1:0] bl);
    pixel_item_t it;
    int unsigned a;
    it.mode  = m;
    it.col   = c;
    it.row   = r;
    it.red   = rd;
    it.green = gr;
    it.blue  = bl;
    item_q.push_back(it);
    a = r * plan_width + c;
    if (m == MODE_WRITE && a < STORE_DEPTH) written_addrs.push_back(a);
  endtask

  // pick a written address and find coordinates that reach it under the
  // current width; recent writes are favored
  function automatic bit find_read_coords(output logic [COORD_BITS-1:0] c,
                                          output logic [COORD_BITS-1:0] r);
    int unsigned n, idx, a, rmin, rmax, rr;
    n = written_addrs.size();
    c = '0;
    r = '0;
    if (n == 0) return 1'b0;
    for (int t = 0; t < 8; t++) begin
      if (n > 8 && $urandom_range(0, 1) == 1) idx = n - 1 - $urandom_range(0, 7);
      else idx = $urandom_range(0, n - 1);
      a    = written_addrs[idx];
      rmax = a / plan_width;
      if (rmax > 127) rmax = 127;
      rmin = (a > 127) ? (a - 127 + plan_width - 1) / plan_width : 0;
      if (rmin <= rmax) begin
        rr = $urandom_range(rmin, rmax);
        r  = rr[COORD_BITS-1:0];
        c  = 7'(a - rr * plan_width);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // random magnitude up to cap_bits wide, so small values stay common
  function automatic logic [CH_BITS-1:0] rand_chan(input int cap_bits);
    int nb;
    nb = $urandom_range(0, cap_bits);
    return CH_BITS'($urandom & ((32'd1 << nb) - 1));
  endfunction

  task automatic random_phase(input int n_items, input int cap_bits);
    logic [COORD_BITS-1:0] c, r;
    for (int i = 0; i < n_items; i++) begin
      // channel fields of a read are don't-care, so they carry noise
      if ($urandom_range(0, 99) < 55 && find_read_coords(c, r))
        add_item(MODE_READ, c, r, CH_BITS'($urandom), CH_BITS'($urandom),
                 CH_BITS'($urandom));
      else
        add_item(MODE_WRITE, 7'($urandom), 7'($urandom), rand_chan(cap_bits),
                 rand_chan(cap_bits), rand_chan(cap_bits));
    end
  endtask

  // wait until every queued item is taken and every result has arrived,
  // then let trailing writes finish
  task automatic drain();
    while (item_q.size() != 0 || n_in_issued != n_in_taken || normalized_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) plan_width = val;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset widths in force; peak starts at zero
    add_item(MODE_WRITE, 7'd0, 7'd0, 16'h0000, 16'h0000, 16'h0000);
    add_item(MODE_READ, 7'd0, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // zero peak: black
    add_item(MODE_WRITE, 7'd127, 7'd127, 16'h0001, 16'h0000, 16'h0000);
    add_item(MODE_READ, 7'd127, 7'd127, 16'h0000, 16'h0000, 16'h0000);
    add_item(MODE_WRITE, 7'd5, 7'd3, 16'h0000, 16'h00FF, 16'h0100);  // peak 256
    add_item(MODE_READ, 7'd5, 7'd3, 16'h0000, 16'h0000, 16'h0000);
    add_item(MODE_READ, 7'd127, 7'd127, 16'h0000, 16'h0000, 16'h0000);
    // 128*255/256 is exactly half way, rounds up
    add_item(MODE_WRITE, 7'd6, 7'd3, 16'h0080, 16'h0001, 16'h0100);
    add_item(MODE_READ, 7'd6, 7'd3, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // width past the store: high rows fall outside, undecoded index ignored
    cfg_write(REG_IMAGE_WIDTH, 8'd255);
    cfg_write(REG_IMAGE_HEIGHT, 8'd128);
    cfg_write(REG_SPARE, 8'h05);
    add_item(MODE_WRITE, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // dropped
    add_item(MODE_READ, 7'd127, 7'd127, 16'h0000, 16'h0000, 16'h0000);   // black
    add_item(MODE_WRITE, 7'd2, 7'd0, 16'h0080, 16'h0000, 16'h0100);
    add_item(MODE_READ, 7'd2, 7'd0, 16'h0000, 16'h0000, 16'h0000);      // peak still 256
    add_item(MODE_READ, 7'd0, 7'd0, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // width of one: coordinates past the image alias onto one another
    cfg_write(REG_IMAGE_WIDTH, 8'd1);
    cfg_write(REG_IMAGE_HEIGHT, 8'd1);
    add_item(MODE_WRITE, 7'd127, 7'd0, 16'h0100, 16'h0080, 16'h0001);
    add_item(MODE_READ, 7'd0, 7'd127, 16'h0000, 16'h0000, 16'h0000);
    add_item(MODE_WRITE, 7'd127, 7'd127, 16'h0055, 16'h00AA, 16'h00FF);
    add_item(MODE_READ, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // random part: peak ceiling widens over the first phases, then stays at full width
    cfg_write(REG_IMAGE_WIDTH, 8'd128);
    cfg_write(REG_IMAGE_HEIGHT, 8'd1);
    random_phase(200, 9);
    drain();

    cfg_write(REG_IMAGE_WIDTH, 8'd1);
    cfg_write(REG_IMAGE_HEIGHT, 8'd128);
    random_phase(180, 12);
    drain();

    cfg_write(REG_IMAGE_WIDTH, 8'($urandom_range(2, 127)));
    cfg_write(REG_IMAGE_HEIGHT, 8'($urandom_range(1, 128)));
    random_phase(220, 14);
    drain();

    cfg_write(REG_IMAGE_WIDTH, 8'd128);
    cfg_write(REG_IMAGE_HEIGHT, 8'd64);
    random_phase(240, CH_BITS);
    drain();

    cfg_write(REG_IMAGE_WIDTH, 8'($urandom_range(1, 128)));
    cfg_write(REG_IMAGE_HEIGHT, 8'($urandom_range(1, 128)));
    random_phase(220, CH_BITS);
    drain();

    cfg_write(REG_IMAGE_WIDTH, 8'd128);
    cfg_write(REG_IMAGE_HEIGHT, 8'd128);
    random_phase(220, CH_BITS);
    drain();

    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run-away guard, far beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
